[rtl/mf2d_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mf2d_pkg
// Shared types and constants of the 2-D median filter.
// ----------------------------------------------------------------------------
package mf2d_pkg;

  localparam int PIX_W     = 8;
  localparam int DIM_REG_W = 9;

  localparam logic [DIM_REG_W-1:0] FRAME_WIDTH_RST  = 9'd160;
  localparam logic [DIM_REG_W-1:0] FRAME_HEIGHT_RST = 9'd120;

  // register index, taken from paddr[2]
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GATHER,
    ST_WAIT,
    ST_MEDIAN,
    ST_EMIT
  } mf2d_state_t;

endpackage

[rtl/median_filter_2d.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// median_filter_2d
// Square-window median filter over a raster stream of 8-bit pixels.
// ----------------------------------------------------------------------------
// Pixels enter on the in_ stream in raster order, one per request; a request
// with in_tuser set is a flush that only advances the drain after the last
// pixel of the frame. Results leave on the out_ stream with a raster delay of
// WINDOW/2 rows plus WINDOW/2 columns; out_tlast marks the frame's final
// pixel, after which the next request starts a new frame. Pixels within half
// a window of an edge pass through, inner pixels get the window median.
// Frame size is set over the cfg_ port (width at 0x0, height at 0x4); a write
// restarts the frame. All rows in flight live in one line store with a write
// port and a separate read port. A request that produces no result leaves
// the input ready; a border result takes one line-store read, an inner
// result one read per window pixel, then an 8-step bitwise median search.
// The input is not ready again until the result register is loaded, which
// frees the input side, so a stalled receiver only holds the block when the
// next result is ready. Reset (rst_n low, synchronous) restores 160x120 and
// clears row, column and delay counters; the line store needs no clearing.
// ----------------------------------------------------------------------------
module median_filter_2d
  import mf2d_pkg::*;
#(
  parameter int WINDOW     = 3,
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  // stream in
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [PIX_W-1:0] in_tdata,   // [7:0] pixel_in
  input  logic [0:0]       in_tuser,   // [0] flush
  // stream out
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [PIX_W-1:0] out_tdata,  // [7:0] filtered_pixel
  output logic             out_tlast,
  // configuration
  input  logic             cfg_psel,
  input  logic             cfg_penable,
  input  logic             cfg_pwrite,
  input  logic [2:0]       cfg_paddr,
  input  logic [31:0]      cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam int HALF    = WINDOW / 2;
  localparam int SPAN    = 2 * HALF + 1;
  localparam int NWIN    = SPAN * SPAN;
  localparam int K_MED   = (NWIN - 1) / 2;
  localparam int SLOT_W  = (SPAN > 1) ? $clog2(SPAN) : 1;
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int OR_W    = $clog2(MAX_HEIGHT);
  localparam int IR_W    = $clog2(MAX_HEIGHT + 1);
  localparam int ADDR_W  = SLOT_W + COL_W;
  localparam int MEM_D   = 1 << ADDR_W;
  localparam int WI_W    = (NWIN > 1) ? $clog2(NWIN) : 1;
  localparam int KW      = $clog2(NWIN + 1);
  localparam int DLY_W   = $clog2(HALF * MAX_WIDTH + HALF + 2);
  localparam int DW0     = (($clog2(MAX_WIDTH + 1) > $clog2(MAX_HEIGHT + 1)) ?
                            $clog2(MAX_WIDTH + 1) : $clog2(MAX_HEIGHT + 1)) + 1;
  localparam int DW      = (DW0 > DIM_REG_W + 1) ? DW0 : DIM_REG_W + 1;

  mf2d_state_t st_r, st_nxt;

  logic [DIM_REG_W-1:0] fw_r, fw_nxt, fh_r, fh_nxt;
  logic [IR_W-1:0]      in_row_r, in_row_nxt;
  logic [COL_W-1:0]     in_col_r, in_col_nxt;
  logic [SLOT_W-1:0]    in_slot_r, in_slot_nxt;
  logic [OR_W-1:0]      out_row_r, out_row_nxt;
  logic [COL_W-1:0]     out_col_r, out_col_nxt;
  logic [SLOT_W-1:0]    out_slot_r, out_slot_nxt;
  logic [DLY_W-1:0]     diff_r, diff_nxt;

  logic [SLOT_W-1:0]    gs_r, gs_nxt, gr_r, gr_nxt, gc_r, gc_nxt;
  logic [WI_W-1:0]      widx_r, widx_nxt;
  logic                 bord_r, bord_nxt;

  logic [PIX_W-1:0]     line_mem [MEM_D];
  logic [PIX_W-1:0]     rd_data_r;
  logic [WI_W-1:0]      rd_idx_r;
  logic                 rd_vld_r;
  logic                 rd_en;
  logic [ADDR_W-1:0]    rd_addr;
  logic                 wr_en;
  logic [ADDR_W-1:0]    wr_addr;

  logic [PIX_W-1:0]     win_r [NWIN];
  logic [NWIN-1:0]      cand_r, cand_nxt;
  logic [NWIN-1:0]      zmask;
  logic [KW-1:0]        k_r, k_nxt, cnt0;
  logic [2:0]           bit_r, bit_nxt;
  logic [PIX_W-1:0]     res_r, res_nxt;

  logic                 out_vld_r, out_vld_nxt;
  logic [PIX_W-1:0]     out_data_r, out_data_nxt;
  logic                 out_last_r, out_last_nxt;

  logic [DW-1:0]        w_d, h_d, r_e, c_e;
  logic [DLY_W-1:0]     dly;
  logic                 cfg_wr, accept, storing, is_border, is_last, emit_go;
  logic [COL_W-1:0]     col_base;

  // frame geometry
  always_comb begin
    if (fw_r == '0) begin
      w_d = DW'(1);
    end else if (DW'(fw_r) > DW'(MAX_WIDTH)) begin
      w_d = DW'(MAX_WIDTH);
    end else begin
      w_d = DW'(fw_r);
    end
    if (fh_r == '0) begin
      h_d = DW'(1);
    end else if (DW'(fh_r) > DW'(MAX_HEIGHT)) begin
      h_d = DW'(MAX_HEIGHT);
    end else begin
      h_d = DW'(fh_r);
    end
  end

  assign dly       = DLY_W'(32'(HALF) * 32'(w_d) + 32'(HALF));
  assign r_e       = DW'(out_row_r);
  assign c_e       = DW'(out_col_r);
  assign is_border = (r_e < DW'(HALF)) || (c_e < DW'(HALF)) ||
                     (r_e + DW'(HALF) >= h_d) || (c_e + DW'(HALF) >= w_d);
  assign is_last   = (r_e + DW'(1) == h_d) && (c_e + DW'(1) == w_d);
  assign storing   = DW'(in_row_r) < h_d;

  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_pready = 1'b1;

  always_comb begin
    case (cfg_paddr[2])
      REG_FRAME_WIDTH:  cfg_prdata = 32'(fw_r);
      REG_FRAME_HEIGHT: cfg_prdata = 32'(fh_r);
      default:          cfg_prdata = '0;
    endcase
  end

  assign in_tready  = (st_r == ST_IDLE);
  assign accept     = in_tvalid & in_tready;
  assign emit_go    = !out_vld_r || out_tready;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // line store access
  assign col_base = bord_r ? out_col_r : out_col_r - COL_W'(HALF);
  assign rd_en    = (st_r == ST_GATHER);
  assign rd_addr  = {gs_r, col_base + COL_W'(gc_r)};
  assign wr_en    = accept && storing && !in_tuser[0];
  assign wr_addr  = {in_slot_r, in_col_r};

  always_comb begin
    for (int i = 0; i < NWIN; i++) begin
      zmask[i] = ~win_r[i][bit_r];
    end
  end

  always_comb begin
    cnt0 = '0;
    for (int i = 0; i < NWIN; i++) begin
      cnt0 = cnt0 + KW'(cand_r[i] & zmask[i]);
    end
  end

  // next state and datapath control
  always_comb begin
    st_nxt       = st_r;
    fw_nxt       = fw_r;
    fh_nxt       = fh_r;
    in_row_nxt   = in_row_r;
    in_col_nxt   = in_col_r;
    in_slot_nxt  = in_slot_r;
    out_row_nxt  = out_row_r;
    out_col_nxt  = out_col_r;
    out_slot_nxt = out_slot_r;
    diff_nxt     = diff_r;
    gs_nxt       = gs_r;
    gr_nxt       = gr_r;
    gc_nxt       = gc_r;
    widx_nxt     = widx_r;
    bord_nxt     = bord_r;
    cand_nxt     = cand_r;
    k_nxt        = k_r;
    bit_nxt      = bit_r;
    res_nxt      = res_r;
    out_vld_nxt  = out_vld_r & ~out_tready;
    out_data_nxt = out_data_r;
    out_last_nxt = out_last_r;

    case (st_r)
      ST_IDLE: begin
        if (accept) begin
          if (storing) begin
            if (!in_tuser[0]) begin
              if (DW'(in_col_r) + DW'(1) >= w_d) begin
                in_col_nxt  = '0;
                in_row_nxt  = in_row_r + IR_W'(1);
                in_slot_nxt = (in_slot_r == SLOT_W'(SPAN - 1)) ? '0 : in_slot_r + SLOT_W'(1);
              end else begin
                in_col_nxt = in_col_r + COL_W'(1);
              end
              if (diff_r >= dly) begin
                st_nxt = ST_GATHER;
              end else begin
                diff_nxt = diff_r + DLY_W'(1);
              end
            end
          end else begin
            st_nxt = ST_GATHER;
          end
          bord_nxt = is_border;
          gr_nxt   = '0;
          gc_nxt   = '0;
          widx_nxt = '0;
          if (is_border) begin
            gs_nxt = out_slot_r;
          end else if (out_slot_r >= SLOT_W'(HALF)) begin
            gs_nxt = out_slot_r - SLOT_W'(HALF);
          end else begin
            gs_nxt = out_slot_r + SLOT_W'(SPAN - HALF);
          end
        end
      end
      ST_GATHER: begin
        widx_nxt = widx_r + WI_W'(1);
        if (gc_r == SLOT_W'(SPAN - 1)) begin
          gc_nxt = '0;
          gr_nxt = gr_r + SLOT_W'(1);
          gs_nxt = (gs_r == SLOT_W'(SPAN - 1)) ? '0 : gs_r + SLOT_W'(1);
        end else begin
          gc_nxt = gc_r + SLOT_W'(1);
        end
        if (bord_r || widx_r == WI_W'(NWIN - 1)) begin
          st_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (bord_r) begin
          res_nxt = rd_data_r;
          st_nxt  = ST_EMIT;
        end else begin
          cand_nxt = '1;
          k_nxt    = KW'(K_MED);
          bit_nxt  = 3'(PIX_W - 1);
          st_nxt   = ST_MEDIAN;
        end
      end
      ST_MEDIAN: begin
        if (k_r < cnt0) begin
          res_nxt[bit_r] = 1'b0;
          cand_nxt       = cand_r & zmask;
        end else begin
          res_nxt[bit_r] = 1'b1;
          k_nxt          = k_r - cnt0;
          cand_nxt       = cand_r & ~zmask;
        end
        if (bit_r == '0) begin
          st_nxt = ST_EMIT;
        end else begin
          bit_nxt = bit_r - 3'd1;
        end
      end
      ST_EMIT: begin
        if (emit_go) begin
          out_vld_nxt  = 1'b1;
          out_data_nxt = res_r;
          out_last_nxt = is_last;
          st_nxt       = ST_IDLE;
          if (is_last) begin
            in_row_nxt   = '0;
            in_col_nxt   = '0;
            in_slot_nxt  = '0;
            out_row_nxt  = '0;
            out_col_nxt  = '0;
            out_slot_nxt = '0;
            diff_nxt     = '0;
          end else if (c_e + DW'(1) >= w_d) begin
            out_col_nxt  = '0;
            out_row_nxt  = out_row_r + OR_W'(1);
            out_slot_nxt = (out_slot_r == SLOT_W'(SPAN - 1)) ? '0 : out_slot_r + SLOT_W'(1);
          end else begin
            out_col_nxt = out_col_r + COL_W'(1);
          end
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase

    if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_FRAME_WIDTH:  fw_nxt = cfg_pwdata[DIM_REG_W-1:0];
        REG_FRAME_HEIGHT: fh_nxt = cfg_pwdata[DIM_REG_W-1:0];
        default:          fw_nxt = fw_r;
      endcase
      in_row_nxt   = '0;
      in_col_nxt   = '0;
      in_slot_nxt  = '0;
      out_row_nxt  = '0;
      out_col_nxt  = '0;
      out_slot_nxt = '0;
      diff_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= ST_IDLE;
      fw_r       <= FRAME_WIDTH_RST;
      fh_r       <= FRAME_HEIGHT_RST;
      in_row_r   <= '0;
      in_col_r   <= '0;
      in_slot_r  <= '0;
      out_row_r  <= '0;
      out_col_r  <= '0;
      out_slot_r <= '0;
      diff_r     <= '0;
      out_vld_r  <= 1'b0;
      rd_vld_r   <= 1'b0;
    end else begin
      st_r       <= st_nxt;
      fw_r       <= fw_nxt;
      fh_r       <= fh_nxt;
      in_row_r   <= in_row_nxt;
      in_col_r   <= in_col_nxt;
      in_slot_r  <= in_slot_nxt;
      out_row_r  <= out_row_nxt;
      out_col_r  <= out_col_nxt;
      out_slot_r <= out_slot_nxt;
      diff_r     <= diff_nxt;
      out_vld_r  <= out_vld_nxt;
      rd_vld_r   <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    gs_r       <= gs_nxt;
    gr_r       <= gr_nxt;
    gc_r       <= gc_nxt;
    widx_r     <= widx_nxt;
    bord_r     <= bord_nxt;
    cand_r     <= cand_nxt;
    k_r        <= k_nxt;
    bit_r      <= bit_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  // line store
  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_mem[wr_addr] <= in_tdata;
    end
    rd_data_r <= line_mem[rd_addr];
    rd_idx_r  <= widx_r;
  end

  // window capture
  always_ff @(posedge clk) begin
    if (rd_vld_r) begin
      win_r[rd_idx_r] <= rd_data_r;
    end
  end

  a_diff_bound: assert property (@(posedge clk) disable iff (!rst_n)
    diff_r <= dly)
    else $error("pending count beyond raster delay");

  a_in_ahead: assert property (@(posedge clk) disable iff (!rst_n)
    DW'(in_row_r) >= DW'(out_row_r))
    else $error("output row ahead of input row");

  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_EMIT && emit_go && is_last && !cfg_wr) |=>
      (in_row_r == '0 && in_col_r == '0 && out_row_r == '0 &&
       out_col_r == '0 && diff_r == '0))
    else $error("counters not cleared after frame end");

  a_median_inner: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_MEDIAN) |-> (!bord_r && !is_border))
    else $error("median search on a border pixel");

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for median_filter_2d. A short table of hand-picked
// requests is run first: reset size, 1x1 frames, a 3x3 frame with one inner
// pixel, early flushes and pixels sent while draining. Then come random
// frames of mostly small sizes, plus one of maximum width and one of maximum
// height, with random gaps on both streams and a long receiver stall at the
// start of each big frame. Every result is checked against a bench-side
// filter model or a table value. Register writes are read back and checked.
// ----------------------------------------------------------------------------
module tb
  import mf2d_pkg::*;
;

  localparam int HALF          = 1;
  localparam int SPAN          = 2 * HALF + 1;
  localparam int MID           = (SPAN * SPAN - 1) / 2;
  localparam int MAX_DIM       = 256;
  localparam int ITEM_TARGET   = 1650;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 40;
  localparam int N_ROWS        = 24;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             last;
  } result_t;

  typedef enum logic [1:0] {ROW_CFG, ROW_PIXEL, ROW_FLUSH} row_kind_t;
  typedef enum logic [1:0] {EXP_PREDICT, EXP_NONE, EXP_VALUE} row_chk_t;

  typedef struct {
    row_kind_t             kind;
    logic                  reg_sel;
    logic [DIM_REG_W-1:0]  data;
    row_chk_t              chk;
    result_t               want;
  } stim_row_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [PIX_W-1:0] in_tdata = '0;    // [7:0] pixel_in
  logic [0:0]       in_tuser = '0;    // [0] flush
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [PIX_W-1:0] out_tdata;        // [7:0] filtered_pixel
  logic             out_tlast;
  logic             cfg_psel = 1'b0;
  logic             cfg_penable = 1'b0;
  logic             cfg_pwrite = 1'b0;
  logic [2:0]       cfg_paddr = '0;
  logic [31:0]      cfg_pwdata = '0;
  logic [31:0]      cfg_prdata;
  logic             cfg_pready;

  median_filter_2d i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // filter model state
  logic [PIX_W-1:0]     line_buf [SPAN][MAX_DIM];
  logic [DIM_REG_W-1:0] width_reg  = FRAME_WIDTH_RST;
  logic [DIM_REG_W-1:0] height_reg = FRAME_HEIGHT_RST;
  int unsigned          src_row = 0, src_col = 0, dst_row = 0, dst_col = 0;

  result_t     awaited_pixels [$];
  int          mismatches  = 0;
  int          tx_idle_pct = 14;
  int          rx_idle_pct = 75;
  int          hold_left   = 0;
  bit          hold_start  = 1'b0;
  int unsigned items_sent  = 0;

  stim_row_t directed_rows [N_ROWS] = '{
    // reset size: early flush, then startup delay
    '{ROW_FLUSH, REG_FRAME_WIDTH,  9'h000, EXP_NONE,    '0},
    '{ROW_PIXEL, REG_FRAME_WIDTH,  9'h000, EXP_NONE,    '0},
    // 1x1 frames, width written as zero
    '{ROW_CFG,   REG_FRAME_WIDTH,  9'd0,   EXP_NONE,    '0},
    '{ROW_CFG,   REG_FRAME_HEIGHT, 9'd1,   EXP_NONE,    '0},
    '{ROW_PIXEL, REG_FRAME_WIDTH,  9'h0FF, EXP_NONE,    '0},
    '{ROW_FLUSH, REG_FRAME_WIDTH,  9'h000, EXP_VALUE,   '{8'hFF, 1'b1}},
    '{ROW_PIXEL, REG_FRAME_WIDTH,  9'h000, EXP_NONE,    '0},
    '{ROW_PIXEL, REG_FRAME_WIDTH,  9'h0A5, EXP_VALUE,   '{8'h00, 1'b1}},
    // 3x3 frame with one inner pixel
    '{ROW_CFG,   REG_FRAME_WIDTH,  9'd3,   EXP_NONE,    '0},
    '{ROW_CFG,   REG_FRAME_HEIGHT, 9'd3,   EXP_NONE,    '0},
    '{ROW_PIXEL, REG_FRAME_WIDTH,  9'h0FF, EXP_PREDICT, '0},
    '{ROW_PIXEL, REG_FRAME_WIDTH,  9'h000, EXP_PREDICT, '0},
    '{ROW_FLUSH, REG_FRAME_WIDTH,  9'h000, EXP_NONE,    '0},
    '{ROW_PIXEL, REG_FRAME_WIDTH,  9'h0FF, EXP_PREDICT, '0},
    '{ROW_PIXEL, REG_FRAME_WIDTH,  9'h000, EXP_PREDICT, '0},
    '{ROW_PIXEL, REG_FRAME_WIDTH,  9'h080, EXP_PREDICT, '0},
    '{ROW_PIXEL, REG_FRAME_WIDTH,  9'h0FF, EXP_PREDICT, '0},
    '{ROW_PIXEL, REG_FRAME_WIDTH,  9'h000, EXP_PREDICT, '0},
    '{ROW_PIXEL, REG_FRAME_WIDTH,  9'h0FF, EXP_PREDICT, '0},
    '{ROW_PIXEL, REG_FRAME_WIDTH,  9'h001, EXP_PREDICT, '0},
    '{ROW_FLUSH, REG_FRAME_WIDTH,  9'h000, EXP_PREDICT, '0},
    '{ROW_PIXEL, REG_FRAME_WIDTH,  9'h05A, EXP_PREDICT, '0},
    '{ROW_FLUSH, REG_FRAME_WIDTH,  9'h000, EXP_PREDICT, '0},
    '{ROW_FLUSH, REG_FRAME_WIDTH,  9'h000, EXP_PREDICT, '0}
  };

  task automatic report_mismatch(input string msg);
    if (mismatches < 40) $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  function automatic int unsigned dim_used(input logic [DIM_REG_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return 32'(v);
  endfunction

  function automatic logic [PIX_W-1:0] window_median(input int unsigned r,
                                                     input int unsigned c);
    logic [PIX_W-1:0] win [SPAN*SPAN];
    int               n, below, upto;
    n = 0;
    for (int y = -HALF; y <= HALF; y++) begin
      for (int x = -HALF; x <= HALF; x++) begin
        win[n] = line_buf[(int'(r) + y) % SPAN][int'(c) + x];
        n++;
      end
    end
    foreach (win[k]) begin
      below = 0;
      upto  = 0;
      foreach (win[m]) begin
        if (win[m] < win[k]) below++;
        if (win[m] <= win[k]) upto++;
      end
      if (below <= MID && upto > MID) return win[k];
    end
    return win[0];
  endfunction

  function automatic void median_step(input logic [PIX_W-1:0] pix, input bit flush,
                                      output bit emit, output result_t res,
                                      output bit ignored);
    int unsigned w, h, delay, r, c;
    w     = dim_used(width_reg);
    h     = dim_used(height_reg);
    delay = HALF * w + HALF;
    emit    = 1'b0;
    ignored = 1'b0;
    res     = '0;
    if (src_row < h) begin
      if (flush) begin
        ignored = 1'b1;
        return;
      end
      line_buf[src_row % SPAN][src_col] = pix;
      src_col++;
      if (src_col >= w) begin
        src_col = 0;
        src_row++;
      end
      if (src_row * w + src_col <= dst_row * w + dst_col + delay) return;
    end
    r = dst_row;
    c = dst_col;
    if (r < HALF || c < HALF || r + HALF >= h || c + HALF >= w)
      res.pix = line_buf[r % SPAN][c];
    else
      res.pix = window_median(r, c);
    res.last = (r * w + c + 1 >= w * h);
    dst_col++;
    if (dst_col >= w) begin
      dst_col = 0;
      dst_row++;
    end
    if (res.last) begin
      src_row = 0; src_col = 0; dst_row = 0; dst_col = 0;
    end
    emit = 1'b1;
  endfunction

  task automatic send_item(input logic [PIX_W-1:0] pix, input bit flush,
                           input row_chk_t chk, input result_t want,
                           output bit ended, output bit skipped);
    bit      emit;
    result_t res;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pix;
    in_tuser  <= flush;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    median_step(pix, flush, emit, res, skipped);
    case (chk)
      EXP_PREDICT: if (emit) awaited_pixels.push_back(res);
      EXP_VALUE:   awaited_pixels.push_back(want);
      default: ;
    endcase
    ended = emit && res.last;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (awaited_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_access(input bit wr, input logic sel, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= {sel, 2'b00};
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    rdata = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_frame_reg(input logic sel, input logic [31:0] wdata);
    logic [31:0] rd;
    wait_drained();
    apb_access(1'b1, sel, wdata, rd);
    if (sel == REG_FRAME_HEIGHT) height_reg = wdata[DIM_REG_W-1:0];
    else width_reg = wdata[DIM_REG_W-1:0];
    src_row = 0; src_col = 0; dst_row = 0; dst_col = 0;
    apb_access(1'b0, sel, '0, rd);
    if (rd !== {23'b0, wdata[DIM_REG_W-1:0]})
      report_mismatch($sformatf("reg %0d reads %08h, wrote %08h", sel, rd, wdata));
  endtask

  function automatic logic [31:0] reg_word(input logic [DIM_REG_W-1:0] v);
    if ($urandom_range(3) == 0) return ($urandom() & 32'hFFFF_FE00) | v;
    return {23'b0, v};
  endfunction

  function automatic logic [PIX_W-1:0] random_pixel();
    case ($urandom_range(3))
      0:       return $urandom_range(1) ? 8'hFF : 8'h00;
      1:       return 8'h7E + 8'($urandom_range(3));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // result side: random stalls, long hold-off on request
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (awaited_pixels.size() == 0) begin
        report_mismatch($sformatf("unexpected pixel %02h last %0b", out_tdata, out_tlast));
      end else begin
        if (out_tdata !== awaited_pixels[0].pix)
          report_mismatch($sformatf("pixel %02h, want %02h",
                                    out_tdata, awaited_pixels[0].pix));
        if (out_tlast !== awaited_pixels[0].last)
          report_mismatch($sformatf("last %0b, want %0b",
                                    out_tlast, awaited_pixels[0].last));
        void'(awaited_pixels.pop_front());
      end
    end
    if (hold_start) begin
      hold_left  = HOLD_CYCLES;
      hold_start = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  initial begin
    bit                   ended, skipped, flush, force_cfg, abandon, big;
    bit                   wide_done, tall_done;
    logic [DIM_REG_W-1:0] w_val, h_val;
    int unsigned          w_eff, h_eff, stop_at, fed;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG)
        set_frame_reg(directed_rows[i].reg_sel, {23'b0, directed_rows[i].data});
      else
        send_item(directed_rows[i].data[PIX_W-1:0], directed_rows[i].kind == ROW_FLUSH,
                  directed_rows[i].chk, directed_rows[i].want, ended, skipped);
    end

    force_cfg = 1'b1;
    wide_done = 1'b0;
    tall_done = 1'b0;
    while (items_sent < ITEM_TARGET) begin
      big = 1'b0;
      if (!tall_done && items_sent >= 400) begin
        tall_done = 1'b1;
        big       = 1'b1;
        w_val     = 9'($urandom_range(1));
        h_val     = 9'($urandom_range(257, 511));
      end else if (!wide_done && items_sent >= 800) begin
        wide_done = 1'b1;
        big       = 1'b1;
        w_val     = 9'd256;
        h_val     = 9'd3;
      end else begin
        w_val = 9'($urandom_range(14));
        h_val = 9'($urandom_range(10));
      end
      if (big || force_cfg || $urandom_range(99) < 70) begin
        set_frame_reg(REG_FRAME_WIDTH, reg_word(w_val));
        set_frame_reg(REG_FRAME_HEIGHT, reg_word(h_val));
      end else if ($urandom_range(99) < 30) begin
        wait_drained();
      end
      force_cfg = 1'b0;
      // big frames start under a long receiver stall
      if (big) hold_start = 1'b1;
      w_eff   = dim_used(width_reg);
      h_eff   = dim_used(height_reg);
      abandon = !big && ($urandom_range(99) < 10);
      stop_at = $urandom_range(1, w_eff * h_eff);
      fed     = 0;
      ended   = 1'b0;
      while (!ended && !(abandon && fed >= stop_at)) begin
        if (items_sent < 550) begin
          tx_idle_pct = 14;
          rx_idle_pct = 75;
        end else if (items_sent < 1100) begin
          tx_idle_pct = 75;
          rx_idle_pct = 14;
        end else begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
        if (src_row < h_eff) flush = ($urandom_range(99) < 5);
        else flush = ($urandom_range(99) < 70);
        send_item(random_pixel(), flush, EXP_PREDICT, '0, ended, skipped);
        items_sent++;
        if (!skipped) fed++;
      end
      if (abandon) force_cfg = 1'b1;
    end

    wait_drained();
    if (mismatches == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  initial begin
    #(20_000_000);
    $display("tb: errors");
    $finish;
  end

endmodule
